// ----- hdl/teq_pkg.sv -----
// Package for the timed event queue: depths, item types, command, kind, status and cell codes.
`timescale 1ns / 1ps
package teq_pkg;
   localparam int QueueDepth = 16;
   localparam int TagBits    = 16;
   localparam int MaxResults = 16;
   localparam int IdxBits    = $clog2(QueueDepth);
   localparam int ResBits    = $clog2(MaxResults + 1);

   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_REMOVE  = 3'd1;
   localparam logic [2:0] CMD_ADVANCE = 3'd2;
   localparam logic [2:0] CMD_LISTAT  = 3'd3;
   localparam logic [2:0] CMD_LISTALL = 3'd4;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_FIRED  = 2'd1;
   localparam logic [1:0] KIND_LISTED = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_PAST = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Cell operations broadcast along the chain.
   localparam logic [2:0] OP_HOLD   = 3'd0;  // every cell keeps its entry
   localparam logic [2:0] OP_INSERT = 3'd1;  // sorted insert of new_entry
   localparam logic [2:0] OP_REMOVE = 3'd2;  // drop the first entry equal to key
   localparam logic [2:0] OP_POP    = 3'd3;  // drop the head entry
   localparam logic [2:0] OP_ROTATE = 3'd4;  // shift toward cell 0, head wraps to the tail

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] time_arg;
      logic [15:0] event_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  add_status;
      logic [31:0] out_time;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        time_val;
      logic [TagBits-1:0] tag;
   } entry_type;

   // Per-cycle controls broadcast to every cell.
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] key;        // time compared against by insert and remove
      entry_type   new_entry;
   } cell_ctl_type;
endpackage

// ----- hdl/teq_cell.sv -----
// One queue cell: holds an entry and a valid bit, trades entries with its neighbors.
`timescale 1ns / 1ps
module teq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::cell_ctl_type ctl,
   input  teq_pkg::entry_type    prev_entry,
   input  logic                  prev_valid,
   input  logic                  prev_stay,
   input  logic                  prev_hit,
   input  teq_pkg::entry_type    next_entry,
   input  logic                  next_valid,
   output teq_pkg::entry_type    entry,
   output logic                  valid,
   output logic                  stay,
   output logic                  hit
);
   teq_pkg::entry_type entry_ff, entry_in;
   logic valid_ff, valid_in;
   logic match;

   // Local compares and the choice of next entry.
   always_comb begin
      stay     = valid_ff && (entry_ff.time_val <= ctl.key);
      match    = valid_ff && (entry_ff.time_val == ctl.key);
      hit      = prev_hit || match;
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctl.op)
         teq_pkg::OP_INSERT: begin
            // entries at or before the new time stay; the first later cell
            // takes the new entry and the rest move back by one
            if (!stay) begin
               if (prev_stay) begin
                  entry_in = ctl.new_entry;
                  valid_in = 1'b1;
               end else begin
                  entry_in = prev_entry;
                  valid_in = prev_valid;
               end
            end
         end
         teq_pkg::OP_REMOVE: begin
            // from the first match on, every cell pulls from its successor
            if (hit) begin
               entry_in = next_entry;
               valid_in = next_valid;
            end
         end
         teq_pkg::OP_POP, teq_pkg::OP_ROTATE: begin
            entry_in = next_entry;
            valid_in = next_valid;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
endmodule

// ----- hdl/teq_ring.sv -----
// Chain of queue cells; cell 0 is the head, valid entries sit in order from cell 0 up.
`timescale 1ns / 1ps
module teq_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::cell_ctl_type ctl,
   output teq_pkg::entry_type    head,
   output logic                  head_valid,
   output logic                  tail_valid
);
   teq_pkg::entry_type entries [teq_pkg::QueueDepth];
   logic [teq_pkg::QueueDepth-1:0] valids, stays, hits;

   // Each cell sees its predecessor and successor; the last cell's successor
   // is the head when rotating and an empty slot otherwise.
   for (genvar g = 0; g < teq_pkg::QueueDepth; g++) begin : g_cell
      teq_pkg::entry_type prev_e, next_e;
      logic prev_v, prev_s, prev_h, next_v;
      if (g == 0) begin : g_first
         assign prev_e = '0;
         assign prev_v = 1'b0;
         assign prev_s = 1'b1;
         assign prev_h = 1'b0;
      end else begin : g_rest
         assign prev_e = entries[g-1];
         assign prev_v = valids[g-1];
         assign prev_s = stays[g-1];
         assign prev_h = hits[g-1];
      end
      if (g == teq_pkg::QueueDepth - 1) begin : g_last
         assign next_e = entries[0];
         assign next_v = (ctl.op == teq_pkg::OP_ROTATE) && valids[0];
      end else begin : g_mid
         assign next_e = entries[g+1];
         assign next_v = valids[g+1];
      end
      teq_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .prev_entry(prev_e), .prev_valid(prev_v), .prev_stay(prev_s), .prev_hit(prev_h),
         .next_entry(next_e), .next_valid(next_v),
         .entry(entries[g]), .valid(valids[g]), .stay(stays[g]), .hit(hits[g])
      );
   end

   assign head       = entries[0];
   assign head_valid = valids[0];
   assign tail_valid = valids[teq_pkg::QueueDepth-1];
endmodule

// ----- hdl/timed_event_queue_unit.sv -----
// Top level of the timed event queue: command sequencer over a chain of cells.
`timescale 1ns / 1ps
// A command is taken while busy is low: a fixed pass of QueueDepth (16) steps
// over the cell chain, one step per cycle whatever the queue holds, then a
// closing report state; busy stays high from the accepting edge until that
// state ends. Add inserts in one step, remove drops one matching entry per
// step, advance pops one due head per step, and a list rotates the chain once
// around. Results come out on rsp_item with rsp_valid high for one cycle each,
// in queue order, at most 16 per command; each fired or listed item waits in
// pend until the next one is found or the pass ends, and the final item,
// flagged by last, is on the ports in the first cycle that busy is low. The
// receiver cannot stall them.
module timed_event_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  teq_pkg::req_type  req_item,
   output logic              rsp_valid,
   output teq_pkg::rsp_type  rsp_item
);
   typedef enum logic [1:0] {S_IDLE, S_PASS, S_DONE} state_type;

   state_type state_ff, state_in;
   teq_pkg::req_type req_ff, req_in;
   logic [teq_pkg::IdxBits-1:0] step_ff, step_in;
   logic [31:0] now_ff, now_in;
   logic [teq_pkg::ResBits-1:0] nres_ff, nres_in;
   logic [1:0] status_ff, status_in;
   teq_pkg::rsp_type pend_ff, pend_in;
   teq_pkg::rsp_type rsp_ff, rsp_in;
   logic pend_v_ff, pend_v_in;
   logic rsp_valid_ff, rsp_valid_in;

   teq_pkg::cell_ctl_type ctl;
   teq_pkg::entry_type head;
   logic head_valid, tail_valid;
   logic room, take, match;
   logic [32:0] sum;

   // Chain operation for this step, and whether the head is reported.
   always_comb begin
      room  = nres_ff < teq_pkg::ResBits'(teq_pkg::MaxResults);
      take  = 1'b0;
      match = 1'b0;
      ctl.op  = teq_pkg::OP_HOLD;
      ctl.key = req_ff.time_arg;
      ctl.new_entry.time_val = req_ff.time_arg;
      ctl.new_entry.tag      = req_ff.event_tag[teq_pkg::TagBits-1:0];
      if (state_ff == S_PASS) begin
         case (req_ff.cmd)
            teq_pkg::CMD_ADD: begin
               if (step_ff == '0 && status_ff == teq_pkg::ST_OK) ctl.op = teq_pkg::OP_INSERT;
            end
            teq_pkg::CMD_REMOVE: begin
               ctl.op = teq_pkg::OP_REMOVE;
            end
            teq_pkg::CMD_ADVANCE: begin
               // sorted queue: once the head is not due, nothing behind it is
               take = head_valid && head.time_val <= now_ff && room;
               if (take) ctl.op = teq_pkg::OP_POP;
            end
            teq_pkg::CMD_LISTAT, teq_pkg::CMD_LISTALL: begin
               ctl.op = teq_pkg::OP_ROTATE;
               match  = head_valid && room && (req_ff.cmd == teq_pkg::CMD_LISTALL ||
                        head.time_val == req_ff.time_arg);
            end
            default: ;
         endcase
      end
   end

   teq_ring u_ring (
      .clock(clock), .reset(reset), .ctl(ctl),
      .head(head), .head_valid(head_valid), .tail_valid(tail_valid)
   );

   // Sequencer next state; a reported item waits in pend until the next one
   // arrives or the pass ends, so the final one can carry last.
   always_comb begin
      sum          = {1'b0, now_ff} + {1'b0, req_item.time_arg};
      state_in     = state_ff;
      req_in       = req_ff;
      step_in      = step_ff;
      now_in       = now_ff;
      nres_in      = nres_ff;
      status_in    = status_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = S_PASS;
               req_in    = req_item;
               step_in   = '0;
               nres_in   = '0;
               pend_v_in = 1'b0;
               status_in = teq_pkg::ST_OK;
               if (req_item.cmd == teq_pkg::CMD_ADD) begin
                  if (req_item.time_arg < now_ff) status_in = teq_pkg::ST_PAST;
                  else if (tail_valid) status_in = teq_pkg::ST_FULL;
               end
               // current time saturates
               if (req_item.cmd == teq_pkg::CMD_ADVANCE) now_in = sum[32] ? '1 : sum[31:0];
            end
         end
         S_PASS: begin
            if (take || match) begin
               rsp_in       = pend_ff;
               rsp_valid_in = pend_v_ff;
               pend_in      = '{take ? teq_pkg::KIND_FIRED : teq_pkg::KIND_LISTED,
                                teq_pkg::ST_OK, head.time_val, 16'(head.tag), 1'b0};
               pend_v_in    = 1'b1;
               nres_in      = nres_ff + teq_pkg::ResBits'(1);
            end
            step_in = step_ff + teq_pkg::IdxBits'(1);
            if (step_ff == teq_pkg::IdxBits'(teq_pkg::QueueDepth - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            pend_v_in    = 1'b0;
            if (req_ff.cmd == teq_pkg::CMD_ADD) begin
               rsp_in = '{teq_pkg::KIND_ADD, status_ff, 32'd0, 16'd0, 1'b1};
            end else if (pend_v_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in = '{teq_pkg::KIND_NONE, teq_pkg::ST_OK, 32'd0, 16'd0, 1'b1};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ff       <= '0;
         step_ff      <= '0;
         now_ff       <= '0;
         nres_ff      <= '0;
         status_ff    <= teq_pkg::ST_OK;
         pend_ff      <= '0;
         pend_v_ff    <= 1'b0;
         rsp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ff       <= req_in;
         step_ff      <= step_in;
         now_ff       <= now_in;
         nres_ff      <= nres_in;
         status_ff    <= status_in;
         pend_ff      <= pend_in;
         pend_v_ff    <= pend_v_in;
         rsp_ff       <= rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A command ends with exactly one last-flagged result.
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid && rsp_item.last)
      else $error("missing final result");
   // Results before the final one come out while busy.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> busy)
      else $error("stray result");
   // The final result appears once the block is free again.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |-> !busy)
      else $error("final result while busy");
endmodule
